@@ hdl/ems_pkg.sv @@
// shared constants and types for the exponential moving standardizer
`default_nettype none
package ems_pkg;
  localparam int MAX_INIT_BLOCK_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ALPHA_BITS = 17;
  localparam int FLOOR_BITS = 32;
  localparam int LEN_BITS = 7;
  localparam int Z_BITS = 22;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN = 2'd2;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [63:0] U64_MAX = {64{1'b1}};
  localparam logic signed [Z_BITS-1:0] Z_MAX = 22'sd2097151;
  localparam logic signed [Z_BITS-1:0] Z_MIN = -22'sd2097152;

  // one serial divide request: floor(num * 2^shift / den), saturated
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [6:0]  shift;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ hdl/ems_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module ems_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ems_pkg::div_req_t req,
  output ems_pkg::div_rsp_t      rsp
);
  import ems_pkg::*;
  logic [63:0] num, den, rem, quo;
  logic [6:0] shift;
  logic [7:0] idx;
  logic busy, sat, finished;
  logic [64:0] rem_sh;
  logic bit_in;
  logic [7:0] shift_ext;

  assign shift_ext = {1'b0, shift};
  always_comb begin
    bit_in = 1'b0;
    if (idx >= shift_ext) bit_in = num[6'(idx - shift_ext)];
    rem_sh = {rem, bit_in};
  end

  always_ff @(posedge clk) begin
    finished <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      num <= req.num;
      den <= req.den;
      shift <= req.shift;
      idx <= 8'(7'd63 + req.shift);
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      if (rem_sh[64] || rem_sh[63:0] >= den) begin
        rem <= 64'(rem_sh - {1'b0, den});
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[63:0];
        quo <= {quo[62:0], 1'b0};
      end
      if (quo[63]) sat <= 1'b1;
      if (idx == 8'd0) begin
        busy <= 1'b0;
        finished <= 1'b1;
      end else begin
        idx <= idx - 8'd1;
      end
    end
  end
  assign rsp = {finished, (sat ? U64_MAX : quo)};
endmodule
`default_nettype wire

@@ hdl/ems_sqrt.sv @@
// digit-serial integer square root, two radicand bits per cycle
`default_nettype none
module ems_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] v;
  logic [65:0] r;
  logic [5:0] step;
  logic busy;
  logic [65:0] acc, trial;

  always_comb begin
    acc = {r[63:0], v[63:62]};
    trial = {32'd0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      v <= radicand;
      r <= '0;
      root <= '0;
      step <= 6'd31;
    end else if (busy) begin
      v <= {v[61:0], 2'b00};
      if (acc >= trial) begin
        r <= acc - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        r <= acc;
        root <= {root[30:0], 1'b0};
      end
      if (step == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= step - 6'd1;
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/exponential_moving_standardizer_core.sv @@
// exponential moving standardizer: sequencer, leaky sums, init block buffer
// per sample: serial divides, a root and serial multiplies; an output stall repeats the last divide
// a sample that closes an init block also runs the block pass over every held sample
// throughput: one sample at a time, in_ready only while idle; all divides share one serial divider
// reset: sums, counts and registers to reset values; init buffer undefined
`default_nettype none
module exponential_moving_standardizer_core #(
  parameter int MAX_INIT_BLOCK = ems_pkg::MAX_INIT_BLOCK_DEF,
  parameter int SAMPLE_BITS = ems_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ems_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ems_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [SAMPLE_BITS-1:0]            sample,
  input  wire logic                              channel_end,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ems_pkg::Z_BITS-1:0]      standardized,
  output logic                                   last_of_run,
  output logic                                   channel_done
);
  import ems_pkg::*;
  localparam int AW = (MAX_INIT_BLOCK > 1) ? $clog2(MAX_INIT_BLOCK) : 1;

  localparam logic [4:0] S_IDLE = 5'd0, S_BETA = 5'd1, S_WMUL = 5'd2, S_VMUL = 5'd3,
    S_VSUM = 5'd4, S_MEAN = 5'd5, S_DEV = 5'd6, S_SQ = 5'd7, S_SMUL = 5'd8,
    S_VAR = 5'd9, S_SQRT = 5'd10, S_ZDIV = 5'd11, S_EMIT = 5'd12, S_BRD = 5'd13,
    S_BACC = 5'd14, S_BSQ = 5'd15, S_BNQ = 5'd16, S_BSS = 5'd17, S_BVAR = 5'd18,
    S_BMEAN = 5'd19, S_BRD2 = 5'd20, S_BDEV = 5'd21, S_END = 5'd22, S_WAIT = 5'd23,
    S_BSQRT = 5'd24;

  logic [ALPHA_BITS-1:0] alpha_weight;
  logic [FLOOR_BITS-1:0] deviation_floor;
  logic [LEN_BITS-1:0] init_block_length;

  logic [4:0] state;
  logic [33:0] weight_sum;
  logic signed [47:0] value_sum;
  logic [63:0] square_sum;
  logic [LEN_BITS-1:0] sample_count, idx;
  logic block_done, end_flag, blk_mode;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [16:0] beta;
  logic signed [SAMPLE_BITS-1:0] buffer [MAX_INIT_BLOCK];
  logic signed [SAMPLE_BITS-1:0] rd;

  // shift-add multiplier: acc += a when b lsb set, one bit per cycle
  logic [127:0] ma, macc;
  logic [63:0] mb;
  logic [6:0] mcnt;
  logic mbusy;

  logic signed [64:0] mean, dev, s_acc;
  logic [63:0] dm, q_acc, t64, bq;
  logic [63:0] denom;
  logic dev_neg;

  div_req_t dreq;
  div_rsp_t drsp;
  logic sq_start, sq_done;
  logic [63:0] sq_in;
  logic [31:0] sq_root;

  ems_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  ems_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root));

  logic [LEN_BITS-1:0] len;
  assign len = (init_block_length > LEN_BITS'(MAX_INIT_BLOCK)) ?
    LEN_BITS'(MAX_INIT_BLOCK) : init_block_length;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);

  logic [63:0] sd_ext;
  assign sd_ext = {24'd0, sq_root, 8'd0};

  // alpha of zero counts as the smallest step, above one as one
  always_comb begin
    if (alpha_weight == '0) beta = 17'd65535;
    else if (alpha_weight >= ONE_Q16) beta = '0;
    else beta = ONE_Q16 - alpha_weight;
  end

  // magnitude of a signed value
  function automatic logic [63:0] mag(input logic signed [64:0] v);
    logic signed [64:0] a;
    a = v[64] ? -v : v;
    return a[63:0];
  endfunction

  function automatic logic signed [64:0] clampd(input logic signed [64:0] d);
    if (d > 65'sd4294967295) return 65'sd4294967295;
    if (d < -65'sd4294967295) return -65'sd4294967295;
    return d;
  endfunction

  function automatic logic signed [Z_BITS-1:0] zsat(input logic neg, input logic [63:0] q);
    if (!neg) return (q > 64'd2097151) ? Z_MAX : Z_BITS'(q);
    return (q > 64'd2097152) ? Z_MIN : Z_BITS'(-q);
  endfunction

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) x <= sample;
    rd <= buffer[idx[AW-1:0]];
    if (state == S_IDLE && in_valid && !block_done && (len != '0 || sample_count != '0))
      buffer[sample_count[AW-1:0]] <= sample;
  end

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    sq_start <= 1'b0;
    if (rst) begin
      alpha_weight <= ALPHA_BITS'(66);
      deviation_floor <= FLOOR_BITS'(7);
      init_block_length <= '0;
      state <= S_IDLE;
      weight_sum <= '0;
      value_sum <= '0;
      square_sum <= '0;
      sample_count <= '0;
      block_done <= 1'b0;
      out_valid <= 1'b0;
      mbusy <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ALPHA: alpha_weight <= cfg_data[ALPHA_BITS-1:0];
          REG_FLOOR: deviation_floor <= cfg_data;
          REG_LEN:   init_block_length <= cfg_data[LEN_BITS-1:0];
          default: ;
        endcase
      end
      if (mbusy) begin
        if (mb[0]) macc <= macc + ma;
        ma <= {ma[126:0], 1'b0};
        mb <= {1'b0, mb[63:1]};
        mcnt <= mcnt - 7'd1;
        if (mcnt == 7'd1) mbusy <= 1'b0;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          end_flag <= channel_end;
          blk_mode <= !block_done && (len != '0 || sample_count != '0);
          state <= S_BETA;
        end
        S_BETA: begin
          ma <= {94'd0, weight_sum};
          state <= S_WMUL;
          mbusy <= 1'b1; mcnt <= 7'd17; macc <= '0;
          mb <= {47'd0, beta};
        end
        S_WMUL: if (!mbusy) begin
          weight_sum <= 34'(macc[127:16] + 112'(ONE_Q16));
          ma <= {64'd0, mag({{17{value_sum[47]}}, value_sum})};
          mb <= {47'd0, beta}; macc <= '0; mcnt <= 7'd17; mbusy <= 1'b1;
          state <= S_VMUL;
        end
        S_VMUL: if (!mbusy) begin
          t64 <= macc[79:16];
          state <= S_VSUM;
        end
        S_VSUM: begin
          // new sum with saturation to 48 bits
          logic signed [65:0] v;
          v = 66'(signed'(x)) * 66'sd256 +
              (value_sum[47] ? -$signed({2'b0, t64}) : $signed({2'b0, t64}));
          if (v > 66'sh7FFFFFFFFFFF) value_sum <= 48'sh7FFFFFFFFFFF;
          else if (v < -66'sh800000000000) value_sum <= 48'sh800000000000;
          else value_sum <= 48'(v);
          state <= S_MEAN;
        end
        S_MEAN: begin
          dreq.start <= 1'b1;
          dreq.num <= mag({{17{value_sum[47]}}, value_sum});
          dreq.shift <= 7'd16;
          dreq.den <= {30'd0, weight_sum};
          state <= S_DEV;
        end
        S_DEV: if (drsp.done) begin
          logic signed [64:0] mn, d;
          mn = value_sum[47] ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});
          d = clampd(65'(signed'(x)) * 65'sd256 - mn);
          dev <= d;
          dm <= mag(d);
          ma <= {64'd0, mag(d)}; mb <= mag(d); macc <= '0; mcnt <= 7'd33;
          mbusy <= 1'b1;
          state <= S_SQ;
        end
        S_SQ: if (!mbusy) begin
          q_acc <= macc[79:16];
          ma <= {64'd0, square_sum}; mb <= {47'd0, beta}; macc <= '0;
          mcnt <= 7'd17; mbusy <= 1'b1;
          state <= S_SMUL;
        end
        S_SMUL: if (!mbusy) begin
          logic [64:0] s;
          s = {1'b0, macc[79:16]} + {1'b0, q_acc};
          square_sum <= (macc[127:80] != '0 || s[64]) ? U64_MAX : s[63:0];
          state <= S_VAR;
        end
        S_VAR: begin
          dreq.start <= 1'b1; dreq.num <= square_sum; dreq.shift <= 7'd32;
          dreq.den <= {30'd0, weight_sum};
          state <= S_SQRT;
        end
        S_SQRT: if (drsp.done) begin
          sq_start <= 1'b1; sq_in <= drsp.quo;
          dev_neg <= dev[64];
          state <= S_ZDIV;
          idx <= '0;
        end
        S_ZDIV: if (sq_done) begin
          logic [63:0] dn;
          dn = (sd_ext > {32'd0, deviation_floor}) ? sd_ext : {32'd0, deviation_floor};
          denom <= dn;
          dreq.start <= 1'b1; dreq.num <= dm; dreq.shift <= 7'd25;
          dreq.den <= dn;
          state <= S_EMIT;
        end
        S_EMIT: if (drsp.done || denom == '0) begin
          if (!out_valid || out_ready) begin
            logic [63:0] q;
            if (denom == '0) q = U64_MAX;
            else q = (drsp.quo == U64_MAX) ? U64_MAX : 64'(({1'b0, drsp.quo} + 65'd1) >> 1);
            standardized <= (dm == '0) ? '0 : zsat(dev_neg, q);
            out_valid <= 1'b1;
            if (!blk_mode) begin
              last_of_run <= 1'b1; channel_done <= end_flag;
              block_done <= 1'b1;
              state <= S_END;
            end else begin
              last_of_run <= (idx + 1'b1 == sample_count);
              channel_done <= (idx + 1'b1 == sample_count) && end_flag;
              if (idx + 1'b1 == sample_count) begin
                block_done <= 1'b1; state <= S_END;
              end else begin
                idx <= idx + 1'b1; state <= S_BRD2;
              end
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: if (!out_valid || out_ready) begin
          // divider result lost while stalled: redo the divide
          dreq.start <= 1'b1;
          state <= S_EMIT;
        end
        default: ;
      endcase
      // init block path takes over after the running sums are updated
      if (state == S_ZDIV && sq_done && blk_mode) begin
        logic [LEN_BITS-1:0] c;
        c = sample_count + 1'b1;
        sample_count <= c;
        if (c >= len || end_flag) begin
          idx <= '0; s_acc <= '0; bq <= '0;
          state <= S_BRD;
        end else begin
          state <= S_END;
        end
      end
      if (state == S_BRD) state <= S_BACC;
      if (state == S_BACC) begin
        s_acc <= s_acc + 65'(rd);
        ma <= {64'd0, mag(65'(rd))}; mb <= mag(65'(rd)); macc <= '0;
        mcnt <= 7'(SAMPLE_BITS); mbusy <= 1'b1;
        state <= S_BSQ;
      end
      if (state == S_BSQ && !mbusy) begin
        bq <= bq + macc[63:0];
        if (idx + 1'b1 == sample_count) begin
          ma <= {64'd0, bq + macc[63:0]}; mb <= {57'd0, sample_count};
          macc <= '0; mcnt <= 7'(LEN_BITS); mbusy <= 1'b1;
          state <= S_BNQ;
        end else begin
          idx <= idx + 1'b1; state <= S_BRD;
        end
      end
      if (state == S_BNQ && !mbusy) begin
        bq <= macc[63:0];
        ma <= {64'd0, mag(s_acc)}; mb <= mag(s_acc); macc <= '0;
        mcnt <= 7'd40; mbusy <= 1'b1;
        state <= S_BSS;
      end
      if (state == S_BSS && !mbusy) begin
        dreq.start <= 1'b1; dreq.num <= bq - macc[63:0]; dreq.shift <= 7'd16;
        dreq.den <= 64'(sample_count) * 64'(sample_count);
        state <= S_BVAR;
      end
      if (state == S_BVAR && drsp.done) begin
        sq_start <= 1'b1; sq_in <= drsp.quo;
        dreq.start <= 1'b1; dreq.num <= mag(s_acc); dreq.shift <= 7'd8;
        dreq.den <= {57'd0, sample_count};
        state <= S_BMEAN;
      end
      if (state == S_BMEAN && drsp.done) begin
        mean <= s_acc[64] ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});
        state <= S_BSQRT;
      end
      if (state == S_BSQRT) begin
        denom <= (sd_ext > {32'd0, deviation_floor}) ? sd_ext : {32'd0, deviation_floor};
        idx <= '0;
        state <= S_BRD2;
      end
      if (state == S_BRD2) state <= S_BDEV;
      if (state == S_BDEV) begin
        logic signed [64:0] d;
        d = clampd(65'(rd) * 65'sd256 - mean);
        dev_neg <= d[64];
        dm <= mag(d);
        dreq.start <= 1'b1; dreq.num <= mag(d); dreq.shift <= 7'd25;
        dreq.den <= denom;
        state <= S_EMIT;
      end
      if (state == S_END) begin
        if (end_flag) begin
          weight_sum <= '0; value_sum <= '0; square_sum <= '0;
          sample_count <= '0; block_done <= 1'b0;
        end
        state <= S_IDLE;
      end
    end
  end
endmodule
`default_nettype wire

@@ bench/exponential_moving_standardizer_core_tb.sv @@
// self-checking testbench for the exponential moving standardizer core
`timescale 1ns / 100ps
module exponential_moving_standardizer_core_tb;
  import ems_pkg::*;

  localparam int SETTLE_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int BLOCK_MAX = MAX_INIT_BLOCK_DEF;

  typedef struct {
    logic signed [Z_BITS-1:0] z;
    logic                     last;
    logic                     done;
  } score_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_ALPHA;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_BITS_DEF-1:0] sample = '0;
  logic channel_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [Z_BITS-1:0] standardized;
  logic last_of_run;
  logic channel_done;

  exponential_moving_standardizer_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample), .channel_end(channel_end),
    .out_valid(out_valid), .out_ready(out_ready), .standardized(standardized),
    .last_of_run(last_of_run), .channel_done(channel_done)
  );

  always #10 clk = ~clk;

  // predictor state and register copies
  logic [63:0] alpha_reg, floor_reg, len_reg;
  logic [63:0] weight_acc, square_acc;
  logic signed [63:0] value_acc;
  int unsigned held_count;
  logic signed [63:0] held_samples [BLOCK_MAX];
  logic block_over;

  score_t score_q[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int burst_left = 0;
  int stall_left = 0;

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] leak(logic [63:0] v, logic [63:0] beta);
    return (v >> 16) * beta + (((v & 64'hFFFF) * beta) >> 16);
  endfunction

  // floor(num * 2^shift / den), saturated to all ones
  function automatic logic [63:0] div_sat(logic [63:0] num, int shift, logic [63:0] den);
    logic [63:0] r, q;
    logic sat, top, qb, b;
    int i;
    r = '0; q = '0; sat = 1'b0;
    for (i = 63 + shift; i >= 0; i--) begin
      b = 1'b0;
      if (i >= shift) b = num[i - shift];
      top = r[63];
      r = {r[62:0], b};
      qb = 1'b0;
      if (top || r >= den) begin
        r = r - den;
        qb = 1'b1;
      end
      if (q[63]) sat = 1'b1;
      q = {q[62:0], qb};
    end
    return sat ? U64_MAX : q;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] clamp_dev(logic signed [63:0] d);
    if (d > 64'sh FFFFFFFF) return 64'sh FFFFFFFF;
    if (d < -64'sh FFFFFFFF) return -64'sh FFFFFFFF;
    return d;
  endfunction

  function automatic logic [63:0] divisor(logic [63:0] var_q16);
    logic [63:0] sd;
    sd = int_sqrt(var_q16) << 8;
    return sd > floor_reg ? sd : floor_reg;
  endfunction

  function automatic logic signed [Z_BITS-1:0] z_score(logic signed [63:0] dev,
                                                       logic [63:0] denom);
    logic [63:0] m, q;
    m = mag(dev);
    if (m == 0) return '0;
    if (denom == 0) q = U64_MAX;
    else begin
      q = div_sat(m, 25, denom);
      if (q != U64_MAX) q = (q + 1) >> 1;
    end
    if (dev > 0) return q > 64'd2097151 ? Z_MAX : Z_BITS'(q);
    return q > 64'd2097152 ? Z_MIN : Z_BITS'(-q);
  endfunction

  task automatic reset_predictor();
    alpha_reg = 66; floor_reg = 7; len_reg = 0;
    weight_acc = 0; value_acc = 0; square_acc = 0;
    held_count = 0; block_over = 1'b0;
  endtask

  // advance the leaky sums and queue whatever results this sample causes
  task automatic standardize_sample(logic [SAMPLE_BITS_DEF-1:0] raw, logic fin);
    logic signed [63:0] x, t, v, mean, dev, s, d;
    logic [63:0] a, beta, mm, var_q, dm, q, sm, num, bmean, denom;
    int unsigned len, n, i;
    logic signed [Z_BITS-1:0] z;
    score_t r;
    x = 64'(signed'(raw));
    a = alpha_reg;
    if (a < 1) a = 1;
    if (a > ONE_Q16) a = ONE_Q16;
    beta = 64'(ONE_Q16) - a;
    len = (len_reg > BLOCK_MAX) ? BLOCK_MAX : int'(len_reg);

    weight_acc = 64'(ONE_Q16) + leak(weight_acc, beta);
    mm = leak(mag(value_acc), beta);
    t = value_acc < 0 ? -$signed(mm) : $signed(mm);
    v = x * 256 + t;
    if (v > 64'sh7FFFFFFFFFFF) value_acc = 64'sh7FFFFFFFFFFF;
    else if (v < -64'sh800000000000) value_acc = -64'sh800000000000;
    else value_acc = v;
    mm = div_sat(mag(value_acc), 16, weight_acc);
    mean = value_acc < 0 ? -$signed(mm) : $signed(mm);
    dev = clamp_dev(x * 256 - mean);
    dm = mag(dev);
    mm = (dm * dm) >> 16;
    square_acc = leak(square_acc, beta);
    square_acc = (square_acc > U64_MAX - mm) ? U64_MAX : square_acc + mm;
    var_q = div_sat(square_acc, 32, weight_acc);
    z = z_score(dev, divisor(var_q));

    if (!block_over && (len > 0 || held_count > 0)) begin
      held_samples[held_count % BLOCK_MAX] = x;
      held_count++;
      if (held_count >= len || fin) begin
        n = held_count;
        s = 0; q = 0;
        for (i = 0; i < n; i++) begin
          s = s + held_samples[i];
          q = q + mag(held_samples[i]) * mag(held_samples[i]);
        end
        sm = mag(s);
        num = 64'(n) * q - sm * sm;
        var_q = div_sat(num, 16, 64'(n) * 64'(n));
        bmean = div_sat(sm, 8, 64'(n));
        mean = s < 0 ? -$signed(bmean) : $signed(bmean);
        denom = divisor(var_q);
        for (i = 0; i < n; i++) begin
          d = clamp_dev(held_samples[i] * 256 - mean);
          r.z = z_score(d, denom);
          r.last = (i + 1 == n);
          r.done = r.last && fin;
          score_q.push_back(r);
        end
        block_over = 1'b1;
      end
    end else begin
      block_over = 1'b1;
      r.z = z; r.last = 1'b1; r.done = fin;
      score_q.push_back(r);
    end

    if (fin) begin
      weight_acc = 0; value_acc = 0; square_acc = 0;
      held_count = 0; block_over = 1'b0;
    end
  endtask

  // sender: bursts of random length separated by random gaps
  task automatic send_sample(logic [SAMPLE_BITS_DEF-1:0] raw, logic fin);
    if (!calm && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_valid = 1'b1;
    sample = raw;
    channel_end = fin;
    do @(posedge clk); while (!in_ready);
    standardize_sample(raw, fin);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_settled();
    while (score_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    wait_settled();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ALPHA: alpha_reg = 64'(data[16:0]);
      REG_FLOOR: floor_reg = 64'(data);
      REG_LEN:   len_reg = 64'(data[6:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_default_extremes();
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h000000, 1'b0);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'hFFFFFF, 1'b1);
  endtask

  task automatic test_alpha_limits();
    write_reg(REG_ALPHA, 32'd0);
    send_sample(24'd100, 1'b0);
    send_sample(24'd300, 1'b1);
    write_reg(REG_ALPHA, 32'h1FFFF);
    send_sample(24'd5, 1'b0);
    send_sample(24'h800000, 1'b1);
    write_reg(REG_ALPHA, 32'd65536);
    send_sample(24'd1, 1'b0);
    send_sample(24'd2, 1'b1);
  endtask

  task automatic test_floor_limits();
    write_reg(REG_ALPHA, 32'd30000);
    write_reg(REG_FLOOR, 32'd0);
    send_sample(24'd42, 1'b0);
    send_sample(24'd42, 1'b0);
    send_sample(24'd43, 1'b1);
    write_reg(REG_FLOOR, 32'hFFFFFFFF);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    write_reg(REG_FLOOR, 32'd7);
  endtask

  task automatic test_init_block();
    write_reg(REG_LEN, 32'd1);
    send_sample(24'd9, 1'b0);
    send_sample(24'd11, 1'b1);
    write_reg(REG_LEN, 32'd5);
    send_sample(24'd7, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'd7, 1'b1);     // channel ends inside the block
    write_reg(REG_FLOOR, 32'd0);
    send_sample(24'd3, 1'b0);
    send_sample(24'd3, 1'b1);     // constant block, zero spread
    write_reg(REG_FLOOR, 32'd7);
  endtask

  task automatic test_length_change();
    write_reg(REG_LEN, 32'd10);
    send_sample(24'd1, 1'b0);
    send_sample(24'd2, 1'b0);
    send_sample(24'd3, 1'b0);
    write_reg(REG_LEN, 32'd2);    // count already past the new length
    send_sample(24'd4, 1'b0);
    write_reg(REG_LEN, 32'd0);    // direct output already started, no effect
    send_sample(24'd5, 1'b1);
  endtask

  function automatic logic [SAMPLE_BITS_DEF-1:0] random_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1: return 24'($signed($urandom_range(0, 64)) - 32);
      2: return 24'($signed($urandom_range(0, 4000)) - 2000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_random_channels();
    int sent, n, i;
    logic [CFG_DATA_BITS-1:0] v;
    sent = 0;
    // one full-size block with the length clamped from above the maximum
    write_reg(REG_LEN, 32'd127);
    for (i = 0; i < 70; i++) send_sample(random_sample(), i == 69);
    sent = 70;
    while (sent < 340) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: v = 32'd0;
          1: v = 32'd65536;
          2: v = 32'($urandom_range(65537, 131071));
          default: v = 32'($urandom_range(1, 65535));
        endcase
        write_reg(REG_ALPHA, v);
        case ($urandom_range(0, 4))
          0: v = 32'd0;
          1: v = 32'hFFFFFFFF;
          2: v = $urandom;
          default: v = 32'($urandom_range(0, 1 << 20));
        endcase
        write_reg(REG_FLOOR, v);
        case ($urandom_range(0, 9))
          0: v = 32'd64;
          1: v = 32'($urandom_range(65, 127));
          2, 3, 4: v = 32'd0;
          default: v = 32'($urandom_range(1, 8));
        endcase
        write_reg(REG_LEN, v);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      for (i = 0; i < n; i++) send_sample(random_sample(), i == n - 1);
      sent += n;
    end
    calm = 1'b0;
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (calm) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    score_t e;
    if (!rst && out_valid && out_ready) begin
      if (score_q.size() == 0) begin
        $error("unexpected result transfer: standardized %0d", standardized);
        error_count++;
      end else begin
        e = score_q.pop_front();
        if (standardized !== e.z) begin
          $error("standardized: expected %0d, actual %0d", e.z, standardized);
          error_count++;
        end
        if (last_of_run !== e.last) begin
          $error("last_of_run: expected %0d, actual %0d", e.last, last_of_run);
          error_count++;
        end
        if (channel_done !== e.done) begin
          $error("channel_done: expected %0d, actual %0d", e.done, channel_done);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("exponential_moving_standardizer_core test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_extremes();
    test_alpha_limits();
    test_floor_limits();
    test_init_block();
    test_length_change();
    test_random_channels();
    wait_settled();
    if (error_count == 0 && score_q.size() == 0) begin
      $display("exponential_moving_standardizer_core test passed");
    end else begin
      $display("exponential_moving_standardizer_core test failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/ems_pkg.sv
hdl/ems_divider.sv
hdl/ems_sqrt.sv
hdl/exponential_moving_standardizer_core.sv
bench/exponential_moving_standardizer_core_tb.sv
